/* hdl/dfss_pkg.sv */
// shared constants, codes and controller/datapath interface types for the dipole scan summer
package dfss_pkg;

  localparam int MAX_DIPOLES   = 1024;
  localparam int DIP_IDX_W     = $clog2(MAX_DIPOLES);
  localparam int DIP_CNT_W     = DIP_IDX_W + 1;
  localparam int MAX_GRID_SIDE = 4096;
  localparam int GRID_W        = 12;
  localparam int SIDE_W        = 13;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int STORE_W       = 192;

  // iterative engine lengths
  localparam int MUL_STEPS  = 52;
  localparam int DIV_STEPS  = 120;
  localparam int SQRT_STEPS = 34;
  localparam int PROD_COUNT = 12;
  localparam int CNT_W      = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIPOLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd6;

  // request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_LOAD      = 5'd1;
  localparam op_t OP_START     = 5'd2;
  localparam op_t OP_READ      = 5'd3;
  localparam op_t OP_DIFF      = 5'd4;
  localparam op_t OP_PROD      = 5'd5;
  localparam op_t OP_SING      = 5'd6;
  localparam op_t OP_MUL_T     = 5'd7;
  localparam op_t OP_MUL_D     = 5'd8;
  localparam op_t OP_MUL_STEP  = 5'd9;
  localparam op_t OP_DIV_Q     = 5'd10;
  localparam op_t OP_DIV_T     = 5'd11;
  localparam op_t OP_DIV_STEP  = 5'd12;
  localparam op_t OP_SQRT_INIT = 5'd13;
  localparam op_t OP_SQRT_STEP = 5'd14;
  localparam op_t OP_ACCUM     = 5'd15;
  localparam op_t OP_EMIT      = 5'd16;

  typedef struct packed {
    op_t                  op;
    logic [3:0]           sel;
    logic [DIP_IDX_W-1:0] addr;
  } dp_cmd_t;

  typedef struct packed {
    logic                 p_zero;
    logic                 out_free;
    logic [DIP_CNT_W-1:0] n_eff;
  } dp_status_t;

endpackage

/* hdl/dipole_field_scan_sum_unit.sv */
// top level of the dipole field scan summer: sequencer plus datapath
//
// channel  direction  handshake            payload
// in       to block   in_valid / in_stall  req_type dipole_index pos_x..z mom_x..z
// out      from block out_valid / out_stall field_value grid_col grid_row flags
// cfg      to block   cfg_write            cfg_index cfg_data
//
// a load item writes one slot of the dipole store
// an evaluate item walks every summed dipole; per dipole the bit-serial divider and
// the shift-add multiplier each run twice and the square root once, while a dipole at
// zero distance skips all three
// the result waits in an output register, so the next item is taken at once
// rst is synchronous: registers return to their reset values, store is left as is
// a stalled result holds; the walk ends only once the output register is free
module dipole_field_scan_sum_unit (
  input  logic                              clk,
  input  logic                              rst,
  // item input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [9:0]                        dipole_index,
  input  logic signed [31:0]                pos_x,
  input  logic signed [31:0]                pos_y,
  input  logic signed [31:0]                pos_z,
  input  logic signed [31:0]                mom_x,
  input  logic signed [31:0]                mom_y,
  input  logic signed [31:0]                mom_z,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [47:0]                field_value,
  output logic [11:0]                       grid_col,
  output logic [11:0]                       grid_row,
  output logic                              last_point,
  output logic                              singular,
  output logic                              saturated,
  // configuration writes
  input  logic                              cfg_write,
  input  logic [dfss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dfss_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // command and status between sequencer and datapath
  dfss_pkg::dp_cmd_t    cmd;
  dfss_pkg::dp_status_t status;

  dfss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // store, config, arithmetic engines and output register
  dfss_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .dipole_index (dipole_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .mom_x        (mom_x),
    .mom_y        (mom_y),
    .mom_z        (mom_z),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .field_value  (field_value),
    .grid_col     (grid_col),
    .grid_row     (grid_row),
    .last_point   (last_point),
    .singular     (singular),
    .saturated    (saturated)
  );

endmodule

/* hdl/dfss_ram.sv */
// generic single-port-write ram with registered read
module dfss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/dfss_ctrl.sv */
// sequencer for the dipole scan summer: walks dipoles and steps the shared arithmetic engines
module dfss_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  req_type,
  output logic                  in_stall,
  input  dfss_pkg::dp_status_t  status,
  output dfss_pkg::dp_cmd_t     cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_PROD  = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_MULT  = 4'd6;
  localparam logic [3:0] S_DIVQ  = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_MULD  = 4'd9;
  localparam logic [3:0] S_DIVT  = 4'd10;
  localparam logic [3:0] S_ACCUM = 4'd11;
  localparam logic [3:0] S_NEXT  = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  localparam logic [dfss_pkg::CNT_W-1:0] MUL_LAST  = dfss_pkg::CNT_W'(dfss_pkg::MUL_STEPS);
  localparam logic [dfss_pkg::CNT_W-1:0] DIV_LAST  = dfss_pkg::CNT_W'(dfss_pkg::DIV_STEPS);
  localparam logic [dfss_pkg::CNT_W-1:0] SQRT_LAST = dfss_pkg::CNT_W'(dfss_pkg::SQRT_STEPS);
  localparam logic [dfss_pkg::CNT_W-1:0] PROD_LAST = dfss_pkg::CNT_W'(dfss_pkg::PROD_COUNT - 1);

  logic [3:0]                     state, state_next;
  logic [dfss_pkg::CNT_W-1:0]     cnt, cnt_next;
  logic [dfss_pkg::DIP_CNT_W-1:0] k, k_next, k_inc;

  assign in_stall = (state != S_IDLE);
  assign k_inc    = k + 1'b1;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    k_next     = k;
    cmd.op     = dfss_pkg::OP_NONE;
    cmd.sel    = cnt[3:0];
    cmd.addr   = k[dfss_pkg::DIP_IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == dfss_pkg::REQ_EVAL) begin
            cmd.op     = dfss_pkg::OP_START;
            k_next     = '0;
            state_next = (status.n_eff == '0) ? S_EMIT : S_READ;
          end else begin
            cmd.op = dfss_pkg::OP_LOAD;
          end
        end
      end
      S_READ: begin
        cmd.op     = dfss_pkg::OP_READ;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op     = dfss_pkg::OP_DIFF;
        cnt_next   = '0;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.op = dfss_pkg::OP_PROD;
        if (cnt == PROD_LAST) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cnt_next = '0;
        if (status.p_zero) begin
          cmd.op     = dfss_pkg::OP_SING;
          state_next = S_NEXT;
        end else begin
          state_next = S_MULT;
        end
      end
      S_MULT: begin
        cmd.op = (cnt == '0) ? dfss_pkg::OP_MUL_T : dfss_pkg::OP_MUL_STEP;
        if (cnt == MUL_LAST) begin
          cnt_next   = '0;
          state_next = S_DIVQ;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIVQ: begin
        cmd.op = (cnt == '0) ? dfss_pkg::OP_DIV_Q : dfss_pkg::OP_DIV_STEP;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_SQRT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.op = (cnt == '0) ? dfss_pkg::OP_SQRT_INIT : dfss_pkg::OP_SQRT_STEP;
        if (cnt == SQRT_LAST) begin
          cnt_next   = '0;
          state_next = S_MULD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MULD: begin
        cmd.op = (cnt == '0) ? dfss_pkg::OP_MUL_D : dfss_pkg::OP_MUL_STEP;
        if (cnt == MUL_LAST) begin
          cnt_next   = '0;
          state_next = S_DIVT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIVT: begin
        cmd.op = (cnt == '0) ? dfss_pkg::OP_DIV_T : dfss_pkg::OP_DIV_STEP;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_ACCUM;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ACCUM: begin
        cmd.op     = dfss_pkg::OP_ACCUM;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        k_next     = k_inc;
        state_next = (k_inc == status.n_eff) ? S_EMIT : S_READ;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op     = dfss_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
    end
  end

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (k < status.n_eff))
    else $error("dipole read beyond count");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !status.out_free) |=> (state == S_EMIT))
    else $error("result dropped while output busy");

  a_eval_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && req_type == dfss_pkg::REQ_EVAL)
      |=> (state == S_READ || state == S_EMIT))
    else $error("evaluate item did not start a walk");

  a_sqrt_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> (cnt <= SQRT_LAST))
    else $error("square root step count overrun");

endmodule

/* hdl/dfss_dp.sv */
// datapath: dipole store, config registers, product unit, shift-add multiplier, divider, sqrt
module dfss_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dfss_pkg::dp_cmd_t                    cmd,
  output dfss_pkg::dp_status_t                 status,
  input  logic [dfss_pkg::DIP_IDX_W-1:0]       dipole_index,
  input  logic signed [31:0]                   pos_x,
  input  logic signed [31:0]                   pos_y,
  input  logic signed [31:0]                   pos_z,
  input  logic signed [31:0]                   mom_x,
  input  logic signed [31:0]                   mom_y,
  input  logic signed [31:0]                   mom_z,
  input  logic                                 cfg_write,
  input  logic [dfss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dfss_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [47:0]                   field_value,
  output logic [dfss_pkg::GRID_W-1:0]          grid_col,
  output logic [dfss_pkg::GRID_W-1:0]          grid_row,
  output logic                                 last_point,
  output logic                                 singular,
  output logic                                 saturated
);

  localparam logic [1:0] DST_P  = 2'd0;
  localparam logic [1:0] DST_DR = 2'd1;
  localparam logic [1:0] DST_DM = 2'd2;
  localparam logic [1:0] DST_MR = 2'd3;

  localparam logic [dfss_pkg::SIDE_W-1:0] SIDE_MAX =
    dfss_pkg::SIDE_W'(dfss_pkg::MAX_GRID_SIDE);
  localparam logic [dfss_pkg::DIP_CNT_W-1:0] CNT_MAX =
    dfss_pkg::DIP_CNT_W'(dfss_pkg::MAX_DIPOLES);

  // configuration
  logic [dfss_pkg::DIP_CNT_W-1:0] dipole_count;
  logic signed [31:0]             scan_height;
  logic signed [15:0]             dir_x, dir_y, dir_z;
  logic [dfss_pkg::SIDE_W-1:0]    grid_width, grid_height;
  logic [dfss_pkg::GRID_W-1:0]    col, row;

  // per point and per dipole
  logic signed [31:0]  sx, sy;
  logic signed [32:0]  r0, r1, r2;
  logic signed [31:0]  m0, m1, m2;
  logic signed [65:0]  prod;
  logic [1:0]          prod_dst;
  logic                prod_vld;
  logic [65:0]         p;
  logic signed [50:0]  dr;
  logic signed [49:0]  dm;
  logic signed [66:0]  mr;
  logic                tneg, sneg;
  logic signed [53:0]  s;

  // engines
  logic [119:0] ma, mp, dn;
  logic [51:0]  mb;
  logic [99:0]  dd, rem;
  logic [67:0]  sq_src;
  logic [33:0]  root;
  logic [35:0]  sq_rem;

  logic signed [47:0] acc;
  logic               sing, sat, out_full;

  logic [dfss_pkg::STORE_W-1:0] rd_data;

  dfss_ram #(
    .WIDTH (dfss_pkg::STORE_W),
    .DEPTH (dfss_pkg::MAX_DIPOLES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.op == dfss_pkg::OP_LOAD),
    .waddr (dipole_index),
    .wdata ({pos_x, pos_y, pos_z, mom_x, mom_y, mom_z}),
    .raddr (cmd.addr),
    .rdata (rd_data)
  );

  // product operand select
  logic signed [32:0] op_a, op_b;
  logic [1:0]         op_dst;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_dst = DST_P;
    case (cmd.sel)
      4'd0:  begin op_a = r0; op_b = r0; op_dst = DST_P; end
      4'd1:  begin op_a = r1; op_b = r1; op_dst = DST_P; end
      4'd2:  begin op_a = r2; op_b = r2; op_dst = DST_P; end
      4'd3:  begin op_a = {{17{dir_x[15]}}, dir_x}; op_b = r0; op_dst = DST_DR; end
      4'd4:  begin op_a = {{17{dir_y[15]}}, dir_y}; op_b = r1; op_dst = DST_DR; end
      4'd5:  begin op_a = {{17{dir_z[15]}}, dir_z}; op_b = r2; op_dst = DST_DR; end
      4'd6:  begin
        op_a = {{17{dir_x[15]}}, dir_x}; op_b = {m0[31], m0}; op_dst = DST_DM;
      end
      4'd7:  begin
        op_a = {{17{dir_y[15]}}, dir_y}; op_b = {m1[31], m1}; op_dst = DST_DM;
      end
      4'd8:  begin
        op_a = {{17{dir_z[15]}}, dir_z}; op_b = {m2[31], m2}; op_dst = DST_DM;
      end
      4'd9:  begin op_a = {m0[31], m0}; op_b = r0; op_dst = DST_MR; end
      4'd10: begin op_a = {m1[31], m1}; op_b = r1; op_dst = DST_MR; end
      4'd11: begin op_a = {m2[31], m2}; op_b = r2; op_dst = DST_MR; end
      default: begin op_a = '0; op_b = '0; op_dst = DST_P; end
    endcase
  end

  // magnitudes and signed combine
  logic [66:0] mr_mag;
  logic [50:0] dr_mag;
  logic [52:0] dr3;
  logic [53:0] s_mag;
  logic signed [53:0] qv, s_new;

  always_comb begin
    mr_mag = mr[66] ? (~mr + 67'd1) : mr;
    dr_mag = dr[50] ? (~dr + 51'd1) : dr;
    dr3    = {2'b00, dr_mag} + {1'b0, dr_mag, 1'b0};
    s_mag  = s[53] ? (~s + 54'd1) : s;
    qv     = tneg ? -$signed({2'b00, dn[51:0]}) : $signed({2'b00, dn[51:0]});
    s_new  = qv - {{4{dm[49]}}, dm};
  end

  // divider step
  logic [100:0] rem_sh, rem_sub;
  logic         div_ge;

  always_comb begin
    rem_sh  = {rem, dn[119]};
    rem_sub = rem_sh - {1'b0, dd};
    div_ge  = (rem_sh >= {1'b0, dd});
  end

  // square root step
  logic [37:0] sq_sh, sq_trial, sq_sub;
  logic        sq_ge;

  always_comb begin
    sq_sh    = {sq_rem, sq_src[67:66]};
    sq_trial = {2'b00, root, 2'b01};
    sq_sub   = sq_sh - sq_trial;
    sq_ge    = (sq_sh >= sq_trial);
  end

  // term clamp and sum
  logic [119:0]       limit;
  logic               over;
  logic [47:0]        qm;
  logic signed [48:0] term, sum;
  logic               sum_hi, sum_lo;
  logic signed [47:0] acc_new;

  always_comb begin
    limit   = {72'd0, sneg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF};
    over    = (dn > limit);
    qm      = over ? limit[47:0] : dn[47:0];
    term    = sneg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    sum     = {acc[47], acc} + term;
    sum_hi  = !sum[48] && sum[47];
    sum_lo  = sum[48] && !sum[47];
    acc_new = sum_hi ? 48'sh7FFF_FFFF_FFFF : (sum_lo ? 48'sh8000_0000_0000 : sum[47:0]);
  end

  // grid bookkeeping
  logic [dfss_pkg::SIDE_W-1:0] w_eff, h_eff, col_inc, row_inc;
  logic                        is_last;

  always_comb begin
    w_eff   = (grid_width == '0) ? 13'd1 : ((grid_width > SIDE_MAX) ? SIDE_MAX : grid_width);
    h_eff   = (grid_height == '0) ? 13'd1 :
              ((grid_height > SIDE_MAX) ? SIDE_MAX : grid_height);
    col_inc = {1'b0, col} + 13'd1;
    row_inc = {1'b0, row} + 13'd1;
    is_last = ({1'b0, col} == w_eff - 13'd1) && ({1'b0, row} == h_eff - 13'd1);
  end

  assign status.p_zero   = (p == '0);
  assign status.out_free = !out_full || !out_stall;
  assign status.n_eff    = (dipole_count > CNT_MAX) ? CNT_MAX : dipole_count;
  assign out_valid       = out_full;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      dipole_count <= '0;
      scan_height  <= '0;
      dir_x        <= '0;
      dir_y        <= '0;
      dir_z        <= 16'sh7FFF;
      grid_width   <= 13'd1;
      grid_height  <= 13'd1;
      col          <= '0;
      row          <= '0;
      out_full     <= 1'b0;
      prod_vld     <= 1'b0;
    end else begin
      prod_vld <= (cmd.op == dfss_pkg::OP_PROD);
      if (cfg_write) begin
        unique case (cfg_index)
          dfss_pkg::REG_DIPOLE_COUNT: dipole_count <= cfg_data[dfss_pkg::DIP_CNT_W-1:0];
          dfss_pkg::REG_SCAN_HEIGHT:  scan_height  <= cfg_data;
          dfss_pkg::REG_DIR_X:        dir_x        <= cfg_data[15:0];
          dfss_pkg::REG_DIR_Y:        dir_y        <= cfg_data[15:0];
          dfss_pkg::REG_DIR_Z:        dir_z        <= cfg_data[15:0];
          dfss_pkg::REG_GRID_WIDTH: begin
            grid_width <= cfg_data[dfss_pkg::SIDE_W-1:0];
            col        <= '0;
            row        <= '0;
          end
          dfss_pkg::REG_GRID_HEIGHT: begin
            grid_height <= cfg_data[dfss_pkg::SIDE_W-1:0];
            col         <= '0;
            row         <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.op == dfss_pkg::OP_EMIT) begin
        out_full <= 1'b1;
        if (col_inc >= w_eff) begin
          col <= '0;
          row <= (row_inc >= h_eff) ? '0 : row_inc[dfss_pkg::GRID_W-1:0];
        end else begin
          col <= col_inc[dfss_pkg::GRID_W-1:0];
        end
      end else if (out_full && !out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      dfss_pkg::OP_START: begin
        sx   <= pos_x;
        sy   <= pos_y;
        acc  <= '0;
        sing <= 1'b0;
        sat  <= 1'b0;
      end
      dfss_pkg::OP_DIFF: begin
        r0 <= {sx[31], sx} - {rd_data[191], rd_data[191:160]};
        r1 <= {sy[31], sy} - {rd_data[159], rd_data[159:128]};
        r2 <= {scan_height[31], scan_height} - {rd_data[127], rd_data[127:96]};
        m0 <= rd_data[95:64];
        m1 <= rd_data[63:32];
        m2 <= rd_data[31:0];
        p  <= '0;
        dr <= '0;
        dm <= '0;
        mr <= '0;
      end
      dfss_pkg::OP_PROD: begin
        prod     <= op_a * op_b;
        prod_dst <= op_dst;
      end
      dfss_pkg::OP_SING: sing <= 1'b1;
      dfss_pkg::OP_MUL_T: begin
        ma   <= {53'd0, mr_mag};
        mb   <= dr3[51:0];
        mp   <= '0;
        tneg <= dr[50] ^ mr[66];
      end
      dfss_pkg::OP_MUL_D: begin
        ma <= {54'd0, p};
        mb <= {18'd0, root};
        mp <= '0;
      end
      dfss_pkg::OP_MUL_STEP: begin
        if (mb[0]) begin
          mp <= mp + ma;
        end
        ma <= {ma[118:0], 1'b0};
        mb <= {1'b0, mb[51:1]};
      end
      dfss_pkg::OP_DIV_Q: begin
        dn  <= mp;
        dd  <= {34'd0, p};
        rem <= '0;
      end
      dfss_pkg::OP_DIV_T: begin
        dn   <= {25'd0, s_mag, 41'd0};
        dd   <= mp[99:0];
        rem  <= '0;
        sneg <= s[53];
      end
      dfss_pkg::OP_DIV_STEP: begin
        rem <= div_ge ? rem_sub[99:0] : rem_sh[99:0];
        dn  <= {dn[118:0], div_ge};
      end
      dfss_pkg::OP_SQRT_INIT: begin
        s      <= s_new;
        sq_src <= {2'b00, p};
        root   <= '0;
        sq_rem <= '0;
      end
      dfss_pkg::OP_SQRT_STEP: begin
        sq_rem <= sq_ge ? sq_sub[35:0] : sq_sh[35:0];
        root   <= {root[32:0], sq_ge};
        sq_src <= {sq_src[65:0], 2'b00};
      end
      dfss_pkg::OP_ACCUM: begin
        acc <= acc_new;
        sat <= sat | over | sum_hi | sum_lo;
      end
      dfss_pkg::OP_EMIT: begin
        field_value <= acc;
        grid_col    <= col;
        grid_row    <= row;
        last_point  <= is_last;
        singular    <= sing;
        saturated   <= sat;
      end
      default: begin
      end
    endcase
    if (prod_vld) begin
      case (prod_dst)
        DST_P:   p  <= p + prod[65:0];
        DST_DR:  dr <= dr + prod[50:0];
        DST_DM:  dm <= dm + prod[49:0];
        DST_MR:  mr <= mr + {prod[65], prod};
        default: p  <= p;
      endcase
    end
  end

endmodule

/* tb/tb_dipole_field_scan_sum_unit.sv */
// self-checking testbench for the dipole field scan summer
`timescale 1ns / 1ps

module tb_dipole_field_scan_sum_unit;

  localparam longint RUN_LIMIT   = 64'd12_000_000;  // cycles before the run is declared hung
  localparam int     SETTLE      = 16;              // quiet cycles before a register write
  localparam int     HOLD_CYCLES = 4000;            // long receiver hold-off
  localparam int     PHASE_ITEMS = 188;
  localparam longint SUM_MAX     = 64'sd140737488355327;
  localparam longint SUM_MIN     = -64'sd140737488355328;

  typedef struct packed {
    logic signed [47:0] field;
    logic [11:0]        col;
    logic [11:0]        row;
    logic               last;
    logic               sing;
    logic               sat;
  } scan_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EVAL} row_kind_t;

  // cfg rows: idx is the register, a the data
  // load rows: idx is the slot, a..f position and moment
  // eval rows: a, b scan x and y, c..f junk on ignored fields
  typedef struct {
    row_kind_t    kind;
    logic [9:0]   idx;
    logic [31:0]  a, b, c, d, e, f;
    logic         typed;
    scan_result_t want;
  } plan_row_t;

  localparam scan_result_t NOEXP = '0;
  localparam int PLAN_ROWS = 24;

  plan_row_t plan [PLAN_ROWS] = '{
    // empty sum straight after reset: zero field, single point grid
    '{ROW_EVAL, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      1, '{48'sd0, 12'd0, 12'd0, 1'b1, 1'b0, 1'b0}},
    '{ROW_LOAD, 0, 0, 0, 0, 32'h00010000, 32'h00010000, 32'h00010000, 0, NOEXP},
    '{ROW_LOAD, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
      32'h80000000, 32'h80000000, 32'h80000000, 0, NOEXP},
    '{ROW_LOAD, 2, 32'h80000000, 32'h80000000, 32'h80000000,
      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, NOEXP},
    '{ROW_LOAD, 3, 32'h00020000, 32'hFFFE0000, 32'h00008000,
      32'h00030000, 32'h00000000, 32'hFFFF0000, 0, NOEXP},
    '{ROW_LOAD, 4, 32'hFFFF8000, 32'h00040000, 32'hFFFFC000,
      32'hFFFD0000, 32'h00050000, 32'h00001000, 0, NOEXP},
    '{ROW_LOAD, 5, 32'h00000001, 32'h00000000, 32'hFFFFFFFF,
      32'h00100000, 32'hFFF00000, 32'h00000100, 0, NOEXP},
    '{ROW_LOAD, 6, 32'h00123456, 32'hFFEDCBA9, 32'h00000000,
      32'h0000FFFF, 32'hFFFF0001, 32'h00020000, 0, NOEXP},
    '{ROW_LOAD, 7, 32'h00050000, 32'h00050000, 32'h00050000,
      32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF, 0, NOEXP},
    // top slot index, all index bits set
    '{ROW_LOAD, 1023, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'hC3C3C3C3,
      32'h3C3C3C3C, 32'hF0F0F0F0, 32'h0F0F0F0F, 0, NOEXP},
    '{ROW_CFG, dfss_pkg::REG_DIPOLE_COUNT, 1, 0, 0, 0, 0, 0, 0, NOEXP},
    // scan point right on the dipole: flagged, adds nothing
    '{ROW_EVAL, 0, 0, 0, 32'h12345678, 1, 2, 3,
      1, '{48'sd0, 12'd0, 12'd0, 1'b1, 1'b1, 1'b0}},
    '{ROW_EVAL, 0, 32'h00010000, 0, 0, 0, 0, 0, 0, NOEXP},
    // one lsb away from a unit dipole: the term clamps
    '{ROW_EVAL, 0, 1, 0, 0, 0, 0, 0, 0, NOEXP},
    '{ROW_CFG, dfss_pkg::REG_DIPOLE_COUNT, 8, 0, 0, 0, 0, 0, 0, NOEXP},
    '{ROW_CFG, dfss_pkg::REG_DIR_X, 32'h00008000, 0, 0, 0, 0, 0, 0, NOEXP},
    '{ROW_CFG, dfss_pkg::REG_DIR_Y, 32'h00007FFF, 0, 0, 0, 0, 0, 0, NOEXP},
    '{ROW_CFG, dfss_pkg::REG_DIR_Z, 32'hFFFF8000, 0, 0, 0, 0, 0, 0, NOEXP},
    '{ROW_CFG, dfss_pkg::REG_SCAN_HEIGHT, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, NOEXP},
    '{ROW_EVAL, 0, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0, NOEXP},
    '{ROW_EVAL, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, NOEXP},
    // grid sides out of range: width 0 acts as 1, height above the max clamps
    '{ROW_CFG, dfss_pkg::REG_GRID_WIDTH, 0, 0, 0, 0, 0, 0, 0, NOEXP},
    '{ROW_CFG, dfss_pkg::REG_GRID_HEIGHT, 32'h00001FFF, 0, 0, 0, 0, 0, 0, NOEXP},
    '{ROW_EVAL, 0, 0, 32'h00030000, 0, 0, 0, 0, 0, NOEXP}
  };

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            req_type = dfss_pkg::REQ_LOAD;
  logic [9:0]                      dipole_index = '0;
  logic signed [31:0]              pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0]              mom_x = '0, mom_y = '0, mom_z = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [47:0]              field_value;
  logic [11:0]                     grid_col, grid_row;
  logic                            last_point, singular, saturated;
  logic                            cfg_write = 1'b0;
  logic [dfss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dfss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  dipole_field_scan_sum_unit u_dut (.*);

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the dipole store and of the registers
  logic signed [31:0] dip_px [dfss_pkg::MAX_DIPOLES];
  logic signed [31:0] dip_py [dfss_pkg::MAX_DIPOLES];
  logic signed [31:0] dip_pz [dfss_pkg::MAX_DIPOLES];
  logic signed [31:0] dip_mx [dfss_pkg::MAX_DIPOLES];
  logic signed [31:0] dip_my [dfss_pkg::MAX_DIPOLES];
  logic signed [31:0] dip_mz [dfss_pkg::MAX_DIPOLES];
  logic [10:0] sum_count = '0;
  longint      plane_z = 0;
  longint      dir_vx = 0, dir_vy = 0, dir_vz = 32767;
  logic [12:0] side_w = 13'd1, side_h = 13'd1;
  int          walk_col = 0, walk_row = 0;

  scan_result_t pending_results[$];
  int  fail_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  want_hold = 0;
  int  hold_left = 0;
  longint cycle_count = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
    fail_count++;
  endtask

  // one dipole contribution, fixed point throughout
  function automatic longint dipole_contrib(int k, longint sx, longint sy, longint sz,
                                            inout bit sing, inout bit sat);
    longint r0, r1, r2, m0, m1, m2, dr, dm, qv, s;
    logic signed [127:0] wr0, wr1, wr2, wm0, wm1, wm2, mr;
    logic [127:0] u0, u1, u2, p, t, q, den, root, cand, mag_mr;
    logic [63:0]  adr, sm, lim;
    bit mr_neg, t_neg;
    r0 = sx - longint'(dip_px[k]);
    r1 = sy - longint'(dip_py[k]);
    r2 = sz - longint'(dip_pz[k]);
    m0 = dip_mx[k];
    m1 = dip_my[k];
    m2 = dip_mz[k];
    u0 = (r0 < 0) ? 128'(-r0) : 128'(r0);
    u1 = (r1 < 0) ? 128'(-r1) : 128'(r1);
    u2 = (r2 < 0) ? 128'(-r2) : 128'(r2);
    p = u0 * u0 + u1 * u1 + u2 * u2;
    if (p == 0) begin
      sing = 1'b1;
      return 0;
    end
    dr = dir_vx * r0 + dir_vy * r1 + dir_vz * r2;
    dm = dir_vx * m0 + dir_vy * m1 + dir_vz * m2;
    wr0 = r0; wr1 = r1; wr2 = r2;
    wm0 = m0; wm1 = m1; wm2 = m2;
    mr = wm0 * wr0 + wm1 * wr1 + wm2 * wr2;
    mr_neg = mr < 0;
    mag_mr = mr_neg ? -mr : mr;
    adr = (dr < 0) ? -dr : dr;
    t = mag_mr * (128'(adr) * 3);
    t_neg = (dr < 0) != mr_neg;
    q = t / p;
    qv = t_neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    s = qv - dm;
    // floor square root of the squared distance
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (128'(1) << b);
      if (cand * cand <= p) root = cand;
    end
    den = p * root;
    sm = (s < 0) ? -s : s;
    q = (128'(sm) << 41) / den;
    lim = (s < 0) ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
    if (q > 128'(lim)) begin
      q = 128'(lim);
      sat = 1'b1;
    end
    return (s < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // accepted item: load updates the store, evaluate queues its result
  task automatic account_item(logic typed, scan_result_t want);
    scan_result_t res;
    longint acc, sx, sy;
    int n, w, h;
    bit sing, sat;
    items_sent++;
    if (req_type == dfss_pkg::REQ_LOAD) begin
      dip_px[dipole_index] = pos_x;
      dip_py[dipole_index] = pos_y;
      dip_pz[dipole_index] = pos_z;
      dip_mx[dipole_index] = mom_x;
      dip_my[dipole_index] = mom_y;
      dip_mz[dipole_index] = mom_z;
      return;
    end
    sx = pos_x;
    sy = pos_y;
    acc = 0;
    sing = 0;
    sat = 0;
    n = (sum_count > dfss_pkg::MAX_DIPOLES) ? dfss_pkg::MAX_DIPOLES : sum_count;
    for (int k = 0; k < n; k++) begin
      acc += dipole_contrib(k, sx, sy, plane_z, sing, sat);
      if (acc > SUM_MAX) begin acc = SUM_MAX; sat = 1'b1; end
      if (acc < SUM_MIN) begin acc = SUM_MIN; sat = 1'b1; end
    end
    w = (side_w == 0) ? 1 :
        (side_w > dfss_pkg::MAX_GRID_SIDE) ? dfss_pkg::MAX_GRID_SIDE : side_w;
    h = (side_h == 0) ? 1 :
        (side_h > dfss_pkg::MAX_GRID_SIDE) ? dfss_pkg::MAX_GRID_SIDE : side_h;
    res.field = acc[47:0];
    res.col   = walk_col[11:0];
    res.row   = walk_row[11:0];
    res.last  = (walk_col == w - 1) && (walk_row == h - 1);
    res.sing  = sing;
    res.sat   = sat;
    if (walk_col + 1 >= w) begin
      walk_col = 0;
      walk_row = (walk_row + 1 >= h) ? 0 : walk_row + 1;
    end else begin
      walk_col++;
    end
    pending_results.push_back(typed ? want : res);
  endtask

  // offer one item, with random gaps ahead of it, and hold it until taken
  task automatic send_item(logic kind, logic [9:0] slot, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d, logic [31:0] e, logic [31:0] f,
                           logic typed = 1'b0, scan_result_t want = '0);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    dipole_index <= slot;
    pos_x <= a; pos_y <= b; pos_z <= c;
    mom_x <= d; mom_y <= e; mom_z <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    account_item(typed, want);
  endtask

  // register write once the block has drained
  task automatic write_reg(logic [dfss_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      dfss_pkg::REG_DIPOLE_COUNT: sum_count = data[10:0];
      dfss_pkg::REG_SCAN_HEIGHT:  plane_z = longint'($signed(data));
      dfss_pkg::REG_DIR_X:        dir_vx = longint'($signed(data[15:0]));
      dfss_pkg::REG_DIR_Y:        dir_vy = longint'($signed(data[15:0]));
      dfss_pkg::REG_DIR_Z:        dir_vz = longint'($signed(data[15:0]));
      dfss_pkg::REG_GRID_WIDTH: begin
        side_w = data[12:0];
        walk_col = 0;
        walk_row = 0;
      end
      dfss_pkg::REG_GRID_HEIGHT: begin
        side_h = data[12:0];
        walk_col = 0;
        walk_row = 0;
      end
      default: ;
    endcase
  endtask

  // coordinate or moment: mostly a few units around zero, sometimes the extremes
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 32'h80000000;
      2:       return 32'h7FFFFFFF;
      3:       return 32'h00000000;
      default: return $urandom_range(32'h001FFFFF) - 32'h00100000;
    endcase
  endfunction

  // grid side: small most of the time, out of range now and then
  function automatic logic [12:0] pick_side();
    case ($urandom_range(7))
      0:       return 13'd0;
      1:       return 13'd4096;
      2:       return 13'h1FFF;
      default: return 13'($urandom_range(1, 6));
    endcase
  endfunction

  // results: check against the oldest expectation, then pick the next stall
  always @(posedge clk) begin
    scan_result_t want;
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("simulation failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", field_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (field_value !== want.field) report_mismatch("field_value", field_value, want.field);
        if (grid_col !== want.col)      report_mismatch("grid_col", grid_col, want.col);
        if (grid_row !== want.row)      report_mismatch("grid_row", grid_row, want.row);
        if (last_point !== want.last)   report_mismatch("last_point", last_point, want.last);
        if (singular !== want.sing)     report_mismatch("singular", singular, want.sing);
        if (saturated !== want.sat)     report_mismatch("saturated", saturated, want.sat);
      end
    end
    // long hold-off on request so the input side backs up
    if (want_hold) begin
      hold_left = HOLD_CYCLES;
      want_hold = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    logic [31:0] upper;
    logic        is_load;
    logic [9:0]  slot;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (plan[i].kind)
        ROW_CFG:  write_reg(plan[i].idx[dfss_pkg::CFG_IDX_W-1:0], plan[i].a);
        ROW_LOAD: send_item(dfss_pkg::REQ_LOAD, plan[i].idx, plan[i].a, plan[i].b, plan[i].c,
                            plan[i].d, plan[i].e, plan[i].f);
        default:  send_item(dfss_pkg::REQ_EVAL, plan[i].idx, plan[i].a, plan[i].b, plan[i].c,
                            plan[i].d, plan[i].e, plan[i].f, plan[i].typed, plan[i].want);
      endcase
    end

    // random phases: receiver-heavy gaps, sender-heavy gaps, then none
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 49 : 0;
      rx_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 17 : 0;
      // slots 0..7 are always loaded, so sums stay within written slots
      upper = $urandom;
      write_reg(dfss_pkg::REG_DIPOLE_COUNT,
                {upper[31:11], 11'($urandom_range(0, ph == 2 ? 8 : 4))});
      write_reg(dfss_pkg::REG_SCAN_HEIGHT, pick_q16());
      write_reg(dfss_pkg::REG_DIR_X, (ph == 1) ? 32'h00007FFF : $urandom);
      write_reg(dfss_pkg::REG_DIR_Y, (ph == 1) ? 32'hFFFF8000 : $urandom);
      write_reg(dfss_pkg::REG_DIR_Z, $urandom);
      upper = $urandom;
      write_reg(dfss_pkg::REG_GRID_WIDTH, {upper[31:13], pick_side()});
      upper = $urandom;
      write_reg(dfss_pkg::REG_GRID_HEIGHT, {upper[31:13], pick_side()});
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == 40) want_hold = 1;
        is_load = ($urandom_range(99) < 35) ? dfss_pkg::REQ_LOAD : dfss_pkg::REQ_EVAL;
        slot = ($urandom_range(9) < 7) ? 10'($urandom_range(7)) : 10'($urandom);
        send_item(is_load, slot, pick_q16(), pick_q16(), pick_q16(),
                  pick_q16(), pick_q16(), pick_q16());
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d items sent, %0d results checked, over three stall mixes and a long hold",
             items_sent, results_seen);
    $display("sums of up to eight dipoles, grid sides from 1 to %0d",
             dfss_pkg::MAX_GRID_SIDE);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/dfss_pkg.sv
hdl/dfss_ram.sv
hdl/dfss_ctrl.sv
hdl/dfss_dp.sv
hdl/dipole_field_scan_sum_unit.sv
tb/tb_dipole_field_scan_sum_unit.sv
